@@ rtl/bcet_pkg.sv @@
package bcet_pkg;

    // Fixed field widths of the check transaction
    localparam int ID_BITS    = 5;
    localparam int COORD_BITS = 16;
    localparam int SLOT_BITS  = 2 * ID_BITS;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int MARGIN_BITS = 12;

    // Doubled-unit arithmetic width: 2*pos + size, their difference and its negation
    localparam int SUM_BITS = COORD_BITS + 4;

    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 12'd10;

    // Operation codes
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_STAY  = 2'd2;
    localparam logic [1:0] EV_EXIT  = 2'd3;

    typedef struct packed {
        logic                         operation;
        logic [ID_BITS-1:0]           left_id;
        logic [ID_BITS-1:0]           right_id;
        logic signed [COORD_BITS-1:0] left_x;
        logic signed [COORD_BITS-1:0] left_y;
        logic [SIZE_BITS-1:0]         left_w;
        logic [SIZE_BITS-1:0]         left_h;
        logic signed [COORD_BITS-1:0] right_x;
        logic signed [COORD_BITS-1:0] right_y;
        logic [SIZE_BITS-1:0]         right_w;
        logic [SIZE_BITS-1:0]         right_h;
    } chk_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       overlap;
    } res_item_t;

endpackage

@@ rtl/bcet_pair_mem.sv @@
module bcet_pair_mem #(
    parameter int ADDR_BITS = 10
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic                 wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic                 rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic mem [DEPTH];
    logic rd_data_reg;

    // One write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bcet_overlap.sv @@
module bcet_overlap (
    input  bcet_pkg::chk_item_t                item,
    input  logic [bcet_pkg::MARGIN_BITS-1:0]   margin,
    output logic                               hit
);

    import bcet_pkg::*;

    // One axis in doubled units: |(2lp+ls) - (2rp+rs)| < ls + rs - 2*margin
    function automatic logic axis_hit(
        input logic signed [COORD_BITS-1:0] lp,
        input logic [SIZE_BITS-1:0]         ls,
        input logic signed [COORD_BITS-1:0] rp,
        input logic [SIZE_BITS-1:0]         rs,
        input logic [MARGIN_BITS-1:0]       mg
    );
        logic signed [SUM_BITS-1:0] lc;
        logic signed [SUM_BITS-1:0] rc;
        logic signed [SUM_BITS-1:0] reach;
        logic signed [SUM_BITS-1:0] diff;
        logic signed [SUM_BITS-1:0] ndiff;
        lc    = (SUM_BITS'(lp) <<< 1) + SUM_BITS'(ls);
        rc    = (SUM_BITS'(rp) <<< 1) + SUM_BITS'(rs);
        reach = SUM_BITS'(ls) + SUM_BITS'(rs) - SUM_BITS'({mg, 1'b0});
        diff  = lc - rc;
        ndiff = rc - lc;
        return (diff < reach) && (ndiff < reach);
    endfunction

    assign hit = axis_hit(item.left_x, item.left_w, item.right_x, item.right_w, margin)
              && axis_hit(item.left_y, item.left_h, item.right_y, item.right_h, margin);

endmodule

@@ rtl/box_collision_event_tracker_unit.sv @@
// Box collision event tracker. Each check transaction carries an ordered pair of
// collider ids and two boxes; the result reports enter, stay, exit or none and
// whether the boxes overlap, while a one-bit touching flag per ordered pair is
// updated. Timing: a check transaction can be accepted every cycle unless a sweep
// runs or the output side holds back the stage. It lands in the input stage and
// its result is loaded into the output register once the output side is free.
// The overlap compare and the flag read-modify-write sit in the single stage
// between the two registers, with a bypass for back-to-back checks of the same
// pair. The flags live in a 1024-entry single-write RAM, so after reset and after
// every clear transaction a sweep rewrites it one entry per cycle, and no check
// is accepted while it runs. The margin register (reset 10) is written on the
// cfg channel, which is always ready; write it only while no check transaction
// is in flight, since the stage in progress uses the current margin.
module box_collision_event_tracker_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             chk_valid,
    output logic                             chk_ready,
    input  bcet_pkg::chk_item_t              chk_item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output bcet_pkg::res_item_t              res_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcet_pkg::MARGIN_BITS-1:0] cfg_margin
);

    import bcet_pkg::*;

    logic [MARGIN_BITS-1:0] margin_reg;

    logic                 clr_busy_reg;
    logic                 clr_busy_next;
    logic [SLOT_BITS-1:0] clr_cnt_reg;
    logic [SLOT_BITS-1:0] clr_cnt_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    chk_item_t            s1_item_reg;
    logic                 byp_hit_reg;
    logic                 byp_val_reg;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    res_item_t            res_item_reg;
    res_item_t            res_item_next;

    logic                 chk_acc;
    logic                 s1_adv;
    logic                 s1_is_chk;
    logic                 s1_hit;
    logic                 s1_was;
    logic                 s1_wr;
    logic [SLOT_BITS-1:0] s1_slot;
    logic [SLOT_BITS-1:0] in_slot;
    logic                 mem_rd_data;
    logic                 mem_we;
    logic [SLOT_BITS-1:0] mem_waddr;
    logic                 mem_wdata;

    // Margin register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            margin_reg <= cfg_margin;
        end
    end

    // Handshake control
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res_ready);
    assign chk_ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign chk_acc   = chk_valid && chk_ready;

    assign in_slot = {chk_item.left_id, chk_item.right_id};
    assign s1_slot = {s1_item_reg.left_id, s1_item_reg.right_id};

    // Clear sweep: runs after reset and after each accepted clear transaction
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clr_busy_next = 1'b0;
            end
        end
        else if (chk_acc && chk_item.operation == OP_CLEAR)
        begin
            clr_busy_next = 1'b1;
            clr_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // Input stage
    assign s1_valid_next = chk_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload and bypass of the flag being written at the same edge
    always_ff @(posedge clk)
    begin
        if (chk_acc)
        begin
            s1_item_reg <= chk_item;
            byp_hit_reg <= s1_wr && (s1_slot == in_slot);
            byp_val_reg <= s1_hit;
        end
    end

    // Pair flag storage
    assign mem_we    = clr_busy_reg || s1_wr;
    assign mem_waddr = clr_busy_reg ? clr_cnt_reg : s1_slot;
    assign mem_wdata = clr_busy_reg ? 1'b0 : s1_hit;

    bcet_pair_mem #(
        .ADDR_BITS (SLOT_BITS)
    ) u_pair_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (chk_acc),
        .rd_addr (in_slot),
        .rd_data (mem_rd_data)
    );

    // Overlap compare
    bcet_overlap u_overlap (
        .item   (s1_item_reg),
        .margin (margin_reg),
        .hit    (s1_hit)
    );

    // Event decode and flag update
    assign s1_is_chk = (s1_item_reg.operation == OP_CHECK)
                    && (s1_item_reg.left_id != s1_item_reg.right_id);
    assign s1_was    = byp_hit_reg ? byp_val_reg : mem_rd_data;
    assign s1_wr     = s1_adv && s1_is_chk;

    always_comb
    begin
        res_item_next.overlap   = 1'b0;
        res_item_next.event_res = EV_NONE;
        if (s1_is_chk)
        begin
            res_item_next.overlap = s1_hit;
            case ({s1_hit, s1_was})
                2'b10:   res_item_next.event_res = EV_ENTER;
                2'b11:   res_item_next.event_res = EV_STAY;
                2'b01:   res_item_next.event_res = EV_EXIT;
                default: res_item_next.event_res = EV_NONE;
            endcase
        end
    end

    // Output register
    assign res_valid_next = s1_adv ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

`ifndef SYNTHESIS
    // Sweep and pair update never share the write port
    a_wr_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_busy_reg && s1_wr))
        else $error("pair flag write collides with clear sweep");

    // A clear transaction starts the sweep
    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_acc && chk_item.operation == OP_CLEAR) |=> clr_busy_reg)
        else $error("clear transaction did not start sweep");

    // The sweep walks every slot in order
    a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (clr_busy_reg && $past(clr_busy_reg) && $past(rst_n))
            |-> (clr_cnt_reg == SLOT_BITS'($past(clr_cnt_reg) + 1'b1)))
        else $error("clear sweep skipped a slot");

    // An overlap result is always an enter or a stay
    a_overlap_event: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_item_reg.overlap)
            |-> (res_item_reg.event_res == EV_ENTER || res_item_reg.event_res == EV_STAY))
        else $error("overlap reported with wrong event");
`endif

endmodule
